FILE: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// shared types and constants of the stream find-and-replace block
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int WINDOW_DEPTH    = 8;
   localparam int COUNT_WIDTH     = 4;   // holds 0 .. WINDOW_DEPTH
   localparam int SLOT_WIDTH      = 3;   // indexes one of WINDOW_DEPTH cells
   localparam int LEN_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  final_byte;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic                  byte_valid;
      logic                  run_last;
      logic                  stream_end;
   } rsp_payload_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_RELEASE,
      ST_REPLACE,
      ST_FLUSH,
      ST_MARK
   } sfr_state_type;

endpackage

FILE: hw/rtl/sfr_cell.sv
// ----------------------------------------------------------------------------
// sfr_cell
// one window cell: holds a byte, takes its neighbour's byte on a shift and
// compares its own and its neighbour's byte with its pattern byte
// ----------------------------------------------------------------------------
module sfr_cell
   import sfr_pkg::*;
(
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [BYTE_WIDTH-1:0] load_byte,
   input  logic [BYTE_WIDTH-1:0] next_byte,
   input  logic [BYTE_WIDTH-1:0] pattern_byte,
   output logic [BYTE_WIDTH-1:0] held_byte,
   output logic                  match_here,
   output logic                  match_next
);

   logic [BYTE_WIDTH-1:0] held_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         held_ff <= next_byte;
      end else if (ctl.load) begin
         held_ff <= load_byte;
      end
   end

   assign held_byte  = held_ff;
   assign match_here = (held_ff == pattern_byte);
   // what this cell would hold after one shift
   assign match_next = (next_byte == pattern_byte);

endmodule

FILE: hw/rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// byte stream search and replace over a shifting chain of window cells
// ----------------------------------------------------------------------------
// The block replaces every leftmost, non-overlapping occurrence of the
// configured pattern (1 to 8 bytes) in the byte stream with the configured
// replacement (0 to 8 bytes), one result transfer per output byte. Bytes that
// may still start a match are held in a row of eight cells; bytes that can no
// longer be part of a match are released from the front of the row one per
// cycle while the output is free, as the row shifts towards cell 0. A byte
// with final_byte set flushes the row and tags its last result with
// stream_end; if it leaves nothing to send, a bare marker (byte_valid low) is
// sent instead. Each item is accepted in the idle state and then evaluated;
// its result bytes leave through the single output register, a stalled
// output holds the sequencer, and no new item is taken until it is idle
// again. Configuration is to be written only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module stream_find_and_replace
   import sfr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_payload_type            req_payload,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_payload_type            rsp_payload,

   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // configuration registers
   logic [CSR_DATA_WIDTH-1:0] pattern_bytes_ff;
   logic [LEN_WIDTH-1:0]      pattern_length_ff;
   logic [CSR_DATA_WIDTH-1:0] replacement_bytes_ff;
   logic [LEN_WIDTH-1:0]      replacement_length_ff;

   // sequencer state
   sfr_state_type             state_ff, state_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [SLOT_WIDTH-1:0]     rep_idx_ff, rep_idx_in;
   logic                      final_ff, final_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_ff, rsp_in;

   // cell row
   cell_ctl_type              cell_ctl [WINDOW_DEPTH];
   logic [BYTE_WIDTH-1:0]     held_byte [WINDOW_DEPTH];
   logic [BYTE_WIDTH-1:0]     next_byte [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]   match_here;
   logic [WINDOW_DEPTH-1:0]   match_next;

   // decision terms
   logic [LEN_WIDTH-1:0]      plen;
   logic [LEN_WIDTH-1:0]      rlen;
   logic [COUNT_WIDTH-1:0]    count_dec;
   logic [SLOT_WIDTH-1:0]     wr_slot;
   logic [WINDOW_DEPTH-1:0]   mask_here;
   logic [WINDOW_DEPTH-1:0]   mask_next;
   logic                      prefix_here;
   logic                      prefix_next;
   logic                      full_match;
   logic                      rel_stops;
   logic                      rel_last;
   logic                      rep_last;
   logic                      out_free;
   logic                      emit;
   rsp_payload_type           emit_data;
   logic                      load_en;
   logic                      shift_en;

   // ------------------------------------------------------------------------
   // configuration writes, unknown indexes are ignored
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= LEN_WIDTH'(1);
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_BYTES:      pattern_bytes_ff      <= csr_write_data;
            CSR_PATTERN_LENGTH:     pattern_length_ff     <= csr_write_data[LEN_WIDTH-1:0];
            CSR_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_write_data;
            CSR_REPLACEMENT_LENGTH: replacement_length_ff <= csr_write_data[LEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // effective lengths: empty pattern counts as one byte, both saturate
   always_comb begin
      if (pattern_length_ff == '0) begin
         plen = LEN_WIDTH'(1);
      end else if (pattern_length_ff > LEN_WIDTH'(MAX_PATTERN)) begin
         plen = LEN_WIDTH'(MAX_PATTERN);
      end else begin
         plen = pattern_length_ff;
      end
      if (replacement_length_ff > LEN_WIDTH'(MAX_REPLACEMENT)) begin
         rlen = LEN_WIDTH'(MAX_REPLACEMENT);
      end else begin
         rlen = replacement_length_ff;
      end
   end

   // ------------------------------------------------------------------------
   // cell row: cell i holds window byte i and compares it with pattern byte i
   // ------------------------------------------------------------------------
   generate
      for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
         if (i == WINDOW_DEPTH - 1) begin : g_tail
            assign next_byte[i] = '0;
         end else begin : g_link
            assign next_byte[i] = held_byte[i+1];
         end

         assign cell_ctl[i].shift = shift_en;
         assign cell_ctl[i].load  = load_en && (wr_slot == SLOT_WIDTH'(i));

         sfr_cell u_cell (
            .clock        (clock),
            .ctl          (cell_ctl[i]),
            .load_byte    (req_payload.data_byte),
            .next_byte    (next_byte[i]),
            .pattern_byte (pattern_bytes_ff[i*BYTE_WIDTH +: BYTE_WIDTH]),
            .held_byte    (held_byte[i]),
            .match_here   (match_here[i]),
            .match_next   (match_next[i])
         );
      end
   endgenerate

   // a full row overwrites its last cell
   assign wr_slot   = (count_ff >= COUNT_WIDTH'(WINDOW_DEPTH)) ?
                      SLOT_WIDTH'(WINDOW_DEPTH - 1) : count_ff[SLOT_WIDTH-1:0];
   assign count_dec = count_ff - COUNT_WIDTH'(1);

   // only the held cells take part in the prefix checks
   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         mask_here[i] = (COUNT_WIDTH'(i) < count_ff);
         mask_next[i] = (COUNT_WIDTH'(i) < count_dec);
      end
   end

   assign prefix_here = (count_ff <= plen)  && (&(match_here | ~mask_here));
   // prefix check of the row as it stands after one more release
   assign prefix_next = (count_dec <= plen) && (&(match_next | ~mask_next));
   assign full_match  = (count_ff == plen) && prefix_here;

   // release stops once the rest is a prefix again; a final byte then
   // flushes whatever is left
   assign rel_stops = (count_dec == '0) || prefix_next;
   assign rel_last  = rel_stops && !(final_ff && (count_dec != '0));
   assign rep_last  = ({1'b0, rep_idx_ff} == (rlen - LEN_WIDTH'(1)));

   assign out_free  = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL, ST_RELEASE: begin
            if ((state_ff == ST_EVAL) && full_match) begin
               if (rlen != '0) begin
                  state_in = ST_REPLACE;
               end else if (final_ff) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!prefix_here) begin
               if (out_free) begin
                  if (!rel_stops) begin
                     state_in = ST_RELEASE;
                  end else if (rel_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end
            end else if (final_ff && (count_ff != '0)) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLACE: begin
            if (out_free && rep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free && (count_ff == COUNT_WIDTH'(1))) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // outputs and datapath control
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready  = 1'b0;
      load_en    = 1'b0;
      shift_en   = 1'b0;
      emit       = 1'b0;
      emit_data  = '0;
      count_in   = count_ff;
      rep_idx_in = rep_idx_ff;
      final_in   = final_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               load_en  = 1'b1;
               count_in = {1'b0, wr_slot} + COUNT_WIDTH'(1);
               final_in = req_payload.final_byte;
            end
         end
         ST_EVAL, ST_RELEASE: begin
            if ((state_ff == ST_EVAL) && full_match) begin
               count_in   = '0;
               rep_idx_in = '0;
            end else if (!prefix_here && out_free) begin
               emit                 = 1'b1;
               emit_data.out_byte   = held_byte[0];
               emit_data.byte_valid = 1'b1;
               emit_data.run_last   = rel_last;
               emit_data.stream_end = rel_last && final_ff;
               shift_en             = 1'b1;
               count_in             = count_dec;
            end
         end
         ST_REPLACE: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.out_byte   =
                  replacement_bytes_ff[rep_idx_ff*BYTE_WIDTH +: BYTE_WIDTH];
               emit_data.byte_valid = 1'b1;
               emit_data.run_last   = rep_last;
               emit_data.stream_end = rep_last && final_ff;
               rep_idx_in           = rep_idx_ff + SLOT_WIDTH'(1);
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.out_byte   = held_byte[0];
               emit_data.byte_valid = 1'b1;
               emit_data.run_last   = (count_ff == COUNT_WIDTH'(1));
               emit_data.stream_end = (count_ff == COUNT_WIDTH'(1));
               shift_en             = 1'b1;
               count_in             = count_dec;
            end
         end
         ST_MARK: begin
            if (out_free) begin
               // bare end-of-stream marker
               emit                 = 1'b1;
               emit_data.run_last   = 1'b1;
               emit_data.stream_end = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // output register: loads a new result as the old one leaves
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rep_idx_ff   <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rep_idx_ff   <= rep_idx_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // the row never holds more bytes than it has cells
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(WINDOW_DEPTH))
      else $error("held count beyond window depth");

   // the window is empty while the replacement goes out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLACE) |-> (count_ff == '0))
      else $error("window not cleared on match");

   // release and flush always have a byte left to send
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FLUSH) || (state_ff == ST_RELEASE)) |-> (count_ff != '0))
      else $error("release or flush with empty window");

   // end of stream only on the last result of an item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.stream_end) |-> rsp_payload.run_last)
      else $error("stream end without run last");

   // a result without a byte is only ever the end marker
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.byte_valid) |-> rsp_payload.stream_end)
      else $error("bare result that does not end the stream");
`endif

endmodule

FILE: bench/sfr_stream_checker.sv
// ----------------------------------------------------------------------------
// sfr_stream_checker
// predicts and checks the result stream of the find-and-replace block
// ----------------------------------------------------------------------------
// Watches the register port and both channels. Every accepted input byte
// runs through a local model of the match window. The model's output bytes
// queue up and are compared with each accepted result transfer.
// ----------------------------------------------------------------------------
module sfr_stream_checker
   import sfr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   input  logic                       req_ready,
   input  req_payload_type            req_payload,

   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rsp_payload_type            rsp_payload,

   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,

   output int                         mismatch_count,
   output int                         expected_left,
   output int                         bytes_in,
   output int                         results_out,
   output int                         replacements,
   output int                         stream_ends
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [CSR_DATA_WIDTH-1:0] pattern_word;
   logic [CSR_DATA_WIDTH-1:0] replacement_word;
   logic [LEN_WIDTH-1:0]      pattern_len_reg;
   logic [LEN_WIDTH-1:0]      replacement_len_reg;

   logic [BYTE_WIDTH-1:0]     held_window [WINDOW_DEPTH];
   int unsigned               held_count;

   rsp_payload_type           expected_bytes [$];

   function automatic int unsigned pattern_len_in_use();
      if (pattern_len_reg == 0) return 1;
      if (pattern_len_reg > MAX_PATTERN) return MAX_PATTERN;
      return pattern_len_reg;
   endfunction

   function automatic int unsigned replacement_len_in_use();
      if (replacement_len_reg > MAX_REPLACEMENT) return MAX_REPLACEMENT;
      return replacement_len_reg;
   endfunction

   function automatic bit window_is_pattern_prefix(input int unsigned plen);
      if (held_count > plen) return 1'b0;
      for (int i = 0; i < held_count && i < WINDOW_DEPTH; i++)
         if (held_window[i] != pattern_word[BYTE_WIDTH*i +: BYTE_WIDTH]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void release_front();
      for (int i = 0; i < WINDOW_DEPTH - 1; i++)
         held_window[i] = held_window[i+1];
      held_count--;
   endfunction

   // one input byte through the window, results appended in order
   function automatic void predict_text_bytes(input req_payload_type item);
      logic [BYTE_WIDTH-1:0] emit_bytes [WINDOW_DEPTH];
      int unsigned           n;
      int unsigned           plen;
      int unsigned           rlen;
      rsp_payload_type       result;
      n    = 0;
      plen = pattern_len_in_use();
      if (held_count >= WINDOW_DEPTH) held_count = WINDOW_DEPTH - 1;
      held_window[held_count] = item.data_byte;
      held_count++;
      if (held_count == plen && window_is_pattern_prefix(plen)) begin
         rlen = replacement_len_in_use();
         for (int i = 0; i < rlen && n < WINDOW_DEPTH; i++) begin
            emit_bytes[n] = replacement_word[BYTE_WIDTH*i +: BYTE_WIDTH];
            n++;
         end
         held_count = 0;
         replacements++;
      end else begin
         while (held_count > 0 && !window_is_pattern_prefix(plen)) begin
            if (n < WINDOW_DEPTH) begin
               emit_bytes[n] = held_window[0];
               n++;
            end
            release_front();
         end
      end
      if (item.final_byte) begin
         for (int i = 0; i < held_count && n < WINDOW_DEPTH; i++) begin
            emit_bytes[n] = held_window[i];
            n++;
         end
         held_count = 0;
         stream_ends++;
         if (n == 0) begin
            result = '{out_byte: '0, byte_valid: 1'b0, run_last: 1'b1, stream_end: 1'b1};
            expected_bytes.push_back(result);
            return;
         end
      end
      for (int i = 0; i < n; i++) begin
         result.out_byte   = emit_bytes[i];
         result.byte_valid = 1'b1;
         result.run_last   = (i + 1 == n);
         result.stream_end = (i + 1 == n) && item.final_byte;
         expected_bytes.push_back(result);
      end
   endfunction

   task automatic note_mismatch(input string what, input rsp_payload_type want,
                                input rsp_payload_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected byte %02h valid %b last %b end %b, got byte %02h valid %b last %b end %b",
                  $time, what, want.out_byte, want.byte_valid, want.run_last,
                  want.stream_end, got.out_byte, got.byte_valid, got.run_last,
                  got.stream_end);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         pattern_word        = '0;
         pattern_len_reg     = 1;
         replacement_word    = '0;
         replacement_len_reg = 0;
         held_count          = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_out++;
            if (expected_bytes.size() == 0) begin
               note_mismatch("result with nothing expected", '0, rsp_payload);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_payload.out_byte   !== want.out_byte   ||
                   rsp_payload.byte_valid !== want.byte_valid ||
                   rsp_payload.run_last   !== want.run_last   ||
                   rsp_payload.stream_end !== want.stream_end)
                  note_mismatch("result mismatch", want, rsp_payload);
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PATTERN_BYTES:      pattern_word        = csr_write_data;
               CSR_PATTERN_LENGTH:     pattern_len_reg     = csr_write_data[LEN_WIDTH-1:0];
               CSR_REPLACEMENT_BYTES:  replacement_word    = csr_write_data;
               CSR_REPLACEMENT_LENGTH: replacement_len_reg = csr_write_data[LEN_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            bytes_in++;
            predict_text_bytes(req_payload);
         end
      end
      expected_left = expected_bytes.size();
   end

endmodule

FILE: bench/stream_find_and_replace_tb.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_tb
// stimulus and verdict for the stream find-and-replace block
// ----------------------------------------------------------------------------
// A directed run walks the reset setting, a three-byte pattern, saturated
// lengths, a zero pattern length, an ignored register index and a window
// carried across a setting change. Random phases then stream text built
// mostly from whole and broken copies of the pattern, under varying
// backpressure. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module stream_find_and_replace_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfr_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 3'd5;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 54;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 4;
   localparam int CYCLE_LIMIT     = 600000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   req_payload_type            req_payload      = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   rsp_payload_type            rsp_payload;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   int mismatch_count;
   int expected_left;
   int bytes_in;
   int results_out;
   int replacements;
   int stream_ends;

   // idling knobs, in percent of cycles
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // long receiver hold-off, raised by stimulus and counted by the receiver
   bit hold_off_request   = 1'b0;
   int hold_off_left      = 0;

   // text shaping: the pattern as the block will use it
   logic [CSR_DATA_WIDTH-1:0] text_pattern;
   int                        text_plen    = 1;
   logic [BYTE_WIDTH-1:0]     text_queue [$];
   int                        stream_left  = 5;
   int                        settings_count = 0;
   int                        cycle_count  = 0;

   stream_find_and_replace dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   sfr_stream_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .expected_left    (expected_left),
      .bytes_in         (bytes_in),
      .results_out      (results_out),
      .replacements     (replacements),
      .stream_ends      (stream_ends)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_left    = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_left);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
         IDLE_BOTH:     begin sender_idle_pct = 38; receiver_stall_pct = 38; end
         default: ;
      endcase
   endtask

   // offer one byte and hold it until the transfer; starts and ends on a
   // falling edge, valid left high so the next byte may follow directly
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] value, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: value, final_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // first byte in the low bits; final set on the last one if close is set
   task automatic send_bytes(input logic [63:0] text, input int count, input logic close);
      for (int i = 0; i < count; i++)
         send_byte(text[BYTE_WIDTH*i +: BYTE_WIDTH], close && (i == count - 1));
   endtask

   // stop offering and wait for the block to go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
   endtask

   // all four registers; upper bits of the length words are junk on purpose
   task automatic configure(input logic [CSR_DATA_WIDTH-1:0] pattern,
                            input logic [LEN_WIDTH-1:0] plen,
                            input logic [CSR_DATA_WIDTH-1:0] replacement,
                            input logic [LEN_WIDTH-1:0] rlen);
      logic [CSR_DATA_WIDTH-1:0] length_word;
      write_register(CSR_PATTERN_BYTES, pattern);
      length_word = {$urandom, $urandom};
      length_word[LEN_WIDTH-1:0] = plen;
      write_register(CSR_PATTERN_LENGTH, length_word);
      write_register(CSR_REPLACEMENT_BYTES, replacement);
      length_word = {$urandom, $urandom};
      length_word[LEN_WIDTH-1:0] = rlen;
      write_register(CSR_REPLACEMENT_LENGTH, length_word);
      csr_write_enable <= 1'b0;
      settings_count++;
      text_pattern = pattern;
      text_plen    = (plen == 0) ? 1 : (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
      text_queue.delete();
   endtask

   // either any byte or one that occurs somewhere in the pattern
   function automatic logic [BYTE_WIDTH-1:0] random_text_byte();
      int slot;
      if ($urandom_range(1)) return BYTE_WIDTH'($urandom_range(255));
      slot = $urandom_range(text_plen - 1);
      return text_pattern[BYTE_WIDTH*slot +: BYTE_WIDTH];
   endfunction

   // text is mostly whole pattern copies, some broken prefixes, some noise
   task automatic next_text_byte(output logic [BYTE_WIDTH-1:0] value, output logic last);
      int kind;
      int prefix_len;
      if (text_queue.size() == 0) begin
         kind = $urandom_range(9);
         if (kind < 5) begin
            for (int i = 0; i < text_plen; i++)
               text_queue.push_back(text_pattern[BYTE_WIDTH*i +: BYTE_WIDTH]);
         end else if (kind < 7 && text_plen > 1) begin
            prefix_len = $urandom_range(text_plen - 1, 1);
            for (int i = 0; i < prefix_len; i++)
               text_queue.push_back(text_pattern[BYTE_WIDTH*i +: BYTE_WIDTH]);
            text_queue.push_back(random_text_byte());
         end else begin
            text_queue.push_back(random_text_byte());
         end
      end
      value = text_queue.pop_front();
      stream_left--;
      last = (stream_left == 0);
      if (last) stream_left = $urandom_range(24, 1);
   endtask

   initial begin
      logic [CSR_DATA_WIDTH-1:0] pattern;
      logic [CSR_DATA_WIDTH-1:0] replacement;
      logic [LEN_WIDTH-1:0]      plen;
      logic [LEN_WIDTH-1:0]      rlen;
      logic [BYTE_WIDTH-1:0]     value;
      logic                      last;
      logic [BYTE_WIDTH-1:0]     base;
      int                        pick;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---------------- directed ----------------
      set_idling(IDLE_NONE);

      // reset setting: a zero byte is the pattern and is deleted
      send_bytes(64'h00, 1, 1'b0);
      send_bytes(64'hFF, 1, 1'b0);
      // final byte that leaves nothing: bare end marker
      send_bytes(64'h00, 1, 1'b1);
      drain();

      // "abc" becomes "XY"
      configure(64'h636261, 4'd3, 64'h5958, 4'd2);
      send_bytes(64'h636261, 3, 1'b0);
      // broken prefix, released byte by byte
      send_bytes(64'h806261, 3, 1'b0);
      // flush of a partial match on the final byte
      send_bytes(64'h6261, 2, 1'b1);
      // partial match left in the window across the next setting
      send_bytes(64'h6261, 2, 1'b0);
      drain();

      // both lengths above the limit, saturating to eight; the held bytes
      // no longer fit the new pattern and come out first
      configure(64'hFFEEDDCCBBAA9988, 4'd15, 64'h0123456789ABCDEF, 4'd15);
      send_bytes(64'hFFEEDDCCBBAA9988, 8, 1'b0);
      send_bytes(64'h00, 1, 1'b1);
      drain();

      // unused index is ignored; pattern length zero acts as one
      write_register(CSR_UNUSED_INDEX, '1);
      configure(64'h41, 4'd0, 64'h5A, 4'd1);
      send_bytes(64'h41, 1, 1'b1);
      send_bytes(64'h4100, 2, 1'b1);
      drain();

      // ---------------- random phases ----------------
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if ($urandom_range(1)) begin
            // two-letter alphabet gives self-overlapping patterns
            base = BYTE_WIDTH'($urandom_range(255));
            for (int i = 0; i < MAX_PATTERN; i++)
               pattern[BYTE_WIDTH*i +: BYTE_WIDTH] = base ^ BYTE_WIDTH'($urandom_range(1));
         end else begin
            pattern = {$urandom, $urandom};
         end
         replacement = {$urandom, $urandom};
         case (phase)
            0: begin plen = 4'd1; rlen = 4'd8; end
            1: begin plen = 4'd8; rlen = 4'd0; end
            2: begin plen = 4'd3; rlen = 4'd8; end
            default: begin
               pick = $urandom_range(9);
               plen = (pick == 0) ? 4'd0 :
                      (pick == 1) ? LEN_WIDTH'($urandom_range(15, 9)) :
                                    LEN_WIDTH'($urandom_range(8, 1));
               pick = $urandom_range(9);
               rlen = (pick == 0) ? LEN_WIDTH'($urandom_range(15, 9)) :
                                    LEN_WIDTH'($urandom_range(8));
            end
         endcase
         configure(pattern, plen, replacement, rlen);
         set_idling(idle_mode_type'(phase % 4));
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // receiver goes deaf for a while as the sender keeps offering
            if (phase == 2 && k == 12) hold_off_request = 1'b1;
            next_text_byte(value, last);
            send_byte(value, last);
         end
         drain();
      end

      $display("run covered %0d input bytes and %0d result transfers over %0d settings",
               bytes_in, results_out, settings_count);
      $display("with %0d pattern replacements and %0d stream ends", replacements, stream_ends);
      if (mismatch_count == 0 && expected_left == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cell.sv
hw/rtl/stream_find_and_replace.sv
bench/sfr_stream_checker.sv
bench/stream_find_and_replace_tb.sv
